/* hdl/dc_delta_bundle_decoder_macros.svh */
// ----------------------------------------------------------------------------
// DC delta bundle decoder assertion macros
// Shared concurrent assertion wrappers; they compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DC_DELTA_BUNDLE_DECODER_MACROS_SVH
`define DC_DELTA_BUNDLE_DECODER_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock while out of reset
`define DCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen while out of reset
`define DCD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DCD_ASSERT(label, prop, msg)
`define DCD_NEVER(label, cond, msg)
`endif

`endif

/* hdl/dcd_pkg.sv */
// ----------------------------------------------------------------------------
// DC delta bundle decoder package
// Shared codes, configuration and command types for the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

  // chunk of entries that share one width field, clamped to 1..8
  localparam int CHUNK_SIZE = 8;
  localparam int CHUNK_EFF  = (CHUNK_SIZE < 1) ? 1 : ((CHUNK_SIZE > 8) ? 8 : CHUNK_SIZE);
  localparam int REPS_W     = 4;
  localparam logic [REPS_W-1:0] CHUNK_EFF_REPS = REPS_W'(CHUNK_EFF);

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // input request function codes
  localparam logic [1:0] FN_DATA  = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_END   = 2'd2;
  localparam logic [1:0] FN_FRAME = 2'd3;

  // result status codes
  localparam logic [2:0] ST_VALUE    = 3'd0;
  localparam logic [2:0] ST_SKIPPED  = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_BITS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_ORDER   = 3'd4;

  typedef struct packed {
    logic [4:0]  count_len;
    logic [4:0]  start_bits;
    logic        signed_mode;
    logic [23:0] capacity_entries;
    logic        bit_order;
  } cfg_t;

  // one command: a value repeated reps times, or a single status item
  typedef struct packed {
    logic [15:0]       value;
    logic [2:0]        status;
    logic [REPS_W-1:0] reps;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* hdl/dcd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// DCD command queue
// Short queue of decoded commands between the parser front and the result back.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_cmd_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  dcd_pkg::cmd_t     push_cmd,
  input  wire               pop,
  output dcd_pkg::cmd_t     head,
  output dcd_pkg::q_stat_t  stat
);

  dcd_pkg::cmd_t                  mem [dcd_pkg::CMDQ_DEPTH];
  logic [dcd_pkg::CMDQ_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [dcd_pkg::CMDQ_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [dcd_pkg::CMDQ_CW-1:0]    cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  localparam logic [dcd_pkg::CMDQ_AW-1:0] PTR_LAST = dcd_pkg::CMDQ_AW'(dcd_pkg::CMDQ_DEPTH - 1);
  localparam logic [dcd_pkg::CMDQ_CW-1:0] CNT_FULL = dcd_pkg::CMDQ_CW'(dcd_pkg::CMDQ_DEPTH);

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* hdl/dcd_front.sv */
// ----------------------------------------------------------------------------
// DCD parser front
// Takes one request a cycle while the command queue has room, walks the bit
// fields and issues one command per request that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_front (
  input  wire                clk,
  input  wire                rst_n,
  input  dcd_pkg::cfg_t      cfg,
  input  wire                in_acc,
  input  wire  [1:0]         in_func,
  input  wire                in_bit_value,
  input  wire                in_unread_pending,
  output logic               cmd_push,
  output dcd_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT,
    PH_SEED,
    PH_SEED_SIGN,
    PH_WIDTH,
    PH_DELTA,
    PH_DELTA_SIGN
  } phase_t;

  localparam logic signed [17:0] SUM_MIN = -18'sd32768;
  localparam logic signed [17:0] SUM_MAX = 18'sd32767;
  localparam logic [4:0]         FLD_MAX = 5'd16;
  localparam logic [4:0]         WIDTH_BITS = 5'd4;

  phase_t             phase_r, phase_nxt;
  logic               act_r, act_nxt;
  logic [23:0]        ew_r, ew_nxt;
  logic [15:0]        field_r, field_nxt;
  logic [4:0]         bl_r, bl_nxt;
  logic [4:0]         ft_r, ft_nxt;
  logic signed [16:0] run_r, run_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [3:0]         cl_r, cl_nxt;
  logic [3:0]         dw_r, dw_nxt;

  logic [4:0]                  cl_eff, start_eff, seed_bits, pos_diff;
  logic [15:0]                 field_ins, field_cur;
  logic [4:0]                  bl_dec;
  logic                        field_done;
  logic [dcd_pkg::REPS_W-1:0]  chunk_min;
  logic                        ovf;
  logic [15:0]                 dmag;
  logic signed [17:0]          run_ext, dmag_ext, delta_sum;
  logic                        out_of_range;
  logic signed [16:0]          seed_signed;
  logic                        emit_go, st_go, last_flag;
  logic [dcd_pkg::REPS_W-1:0]  emit_reps;
  logic [2:0]                  st_code;
  logic [15:0]                 rem_after;
  logic [3:0]                  cl_after;

  // clamped field widths
  assign cl_eff    = (cfg.count_len > FLD_MAX) ? FLD_MAX : cfg.count_len;
  assign start_eff = (cfg.start_bits > FLD_MAX) ? FLD_MAX : cfg.start_bits;
  assign seed_bits = (start_eff > {4'b0, cfg.signed_mode}) ?
                     start_eff - {4'b0, cfg.signed_mode} : 5'd0;

  // bit insertion into the open field
  assign pos_diff   = ft_r - bl_r;
  assign field_ins  = cfg.bit_order ? {field_r[14:0], in_bit_value}
                                    : (field_r | (16'(in_bit_value) << pos_diff[3:0]));
  assign field_cur  = (bl_r != 5'd0) ? field_ins : field_r;
  assign bl_dec     = (bl_r != 5'd0) ? bl_r - 5'd1 : 5'd0;
  assign field_done = (bl_dec == 5'd0);

  // entries in the next chunk
  assign chunk_min = (rem_r < 16'(dcd_pkg::CHUNK_EFF)) ? rem_r[dcd_pkg::REPS_W-1:0]
                                                      : dcd_pkg::CHUNK_EFF_REPS;

  // buffer capacity check on the count just read
  assign ovf = ({1'b0, ew_r} + {9'b0, field_cur}) > {1'b0, cfg.capacity_entries};

  // sign-magnitude delta applied to the running value
  assign dmag         = (phase_r == PH_DELTA_SIGN) ? field_r : 16'd0;
  assign run_ext      = {run_r[16], run_r};
  assign dmag_ext     = {2'b00, dmag};
  assign delta_sum    = in_bit_value ? run_ext - dmag_ext : run_ext + dmag_ext;
  assign out_of_range = (delta_sum < SUM_MIN) || (delta_sum > SUM_MAX);

  // signed seed from magnitude and sign bit
  assign seed_signed = in_bit_value ? -$signed({1'b0, field_r}) : $signed({1'b0, field_r});

  // next state and command
  always_comb begin
    phase_nxt = phase_r;
    act_nxt   = act_r;
    ew_nxt    = ew_r;
    field_nxt = field_r;
    bl_nxt    = bl_r;
    ft_nxt    = ft_r;
    run_nxt   = run_r;
    rem_nxt   = rem_r;
    cl_nxt    = cl_r;
    dw_nxt    = dw_r;
    emit_go   = 1'b0;
    emit_reps = dcd_pkg::REPS_W'(1);
    st_go     = 1'b0;
    st_code   = dcd_pkg::ST_VALUE;
    rem_after = rem_r;
    cl_after  = cl_r;
    last_flag = 1'b0;

    if (in_acc) begin
      case (in_func)
        dcd_pkg::FN_START: begin
          phase_nxt = PH_IDLE;
          if (!act_r || in_unread_pending) begin
            st_go   = 1'b1;
            st_code = dcd_pkg::ST_SKIPPED;
          end else if (cl_eff == 5'd0) begin
            act_nxt = 1'b0;
            st_go   = 1'b1;
            st_code = dcd_pkg::ST_EMPTY;
          end else begin
            phase_nxt = PH_COUNT;
            field_nxt = '0;
            bl_nxt    = cl_eff;
            ft_nxt    = cl_eff;
          end
        end
        dcd_pkg::FN_END: begin
          if (phase_r != PH_IDLE) begin
            phase_nxt = PH_IDLE;
            st_go     = 1'b1;
            st_code   = dcd_pkg::ST_TRUNC;
          end
        end
        dcd_pkg::FN_FRAME: begin
          act_nxt   = 1'b1;
          ew_nxt    = '0;
          phase_nxt = PH_IDLE;
        end
        default: begin
          // data bit
          if (phase_r == PH_SEED_SIGN) begin
            run_nxt = seed_signed;
            emit_go = 1'b1;
          end else if (phase_r == PH_DELTA_SIGN) begin
            if (out_of_range) begin
              phase_nxt = PH_IDLE;
              st_go     = 1'b1;
              st_code   = dcd_pkg::ST_RANGE;
            end else begin
              run_nxt = delta_sum[16:0];
              emit_go = 1'b1;
            end
          end else if (phase_r != PH_IDLE) begin
            field_nxt = field_cur;
            bl_nxt    = bl_dec;
            if (field_done) begin
              if (phase_r == PH_COUNT) begin
                if (field_cur == 16'd0) begin
                  act_nxt   = 1'b0;
                  phase_nxt = PH_IDLE;
                  st_go     = 1'b1;
                  st_code   = dcd_pkg::ST_EMPTY;
                end else if (ovf) begin
                  phase_nxt = PH_IDLE;
                  st_go     = 1'b1;
                  st_code   = dcd_pkg::ST_OVERFLOW;
                end else begin
                  rem_nxt = field_cur;
                  cl_nxt  = 4'd0;
                  if (seed_bits == 5'd0) begin
                    run_nxt = '0;
                    emit_go = 1'b1;
                  end else begin
                    phase_nxt = PH_SEED;
                    field_nxt = '0;
                    bl_nxt    = seed_bits;
                    ft_nxt    = seed_bits;
                  end
                end
              end else if (phase_r == PH_SEED) begin
                if (cfg.signed_mode && (field_cur != 16'd0)) begin
                  phase_nxt = PH_SEED_SIGN;
                end else begin
                  run_nxt = $signed({1'b0, field_cur});
                  emit_go = 1'b1;
                end
              end else if (phase_r == PH_WIDTH) begin
                cl_nxt = chunk_min;
                if (field_cur == 16'd0) begin
                  // zero width: repeat the running value for the whole chunk
                  emit_go   = 1'b1;
                  emit_reps = chunk_min;
                end else begin
                  dw_nxt    = field_cur[3:0];
                  phase_nxt = PH_DELTA;
                  field_nxt = '0;
                  bl_nxt    = {1'b0, field_cur[3:0]};
                  ft_nxt    = {1'b0, field_cur[3:0]};
                end
              end else begin
                // delta magnitude complete
                if (field_cur != 16'd0) begin
                  phase_nxt = PH_DELTA_SIGN;
                end else if (out_of_range) begin
                  phase_nxt = PH_IDLE;
                  st_go     = 1'b1;
                  st_code   = dcd_pkg::ST_RANGE;
                end else begin
                  run_nxt = delta_sum[16:0];
                  emit_go = 1'b1;
                end
              end
            end
          end
        end
      endcase
    end

    // value emission: book-keeping and the next field
    if (emit_go) begin
      ew_nxt    = ew_nxt + {20'b0, emit_reps};
      rem_after = rem_nxt - {12'b0, emit_reps};
      cl_after  = (cl_nxt > emit_reps) ? cl_nxt - emit_reps : 4'd0;
      last_flag = (rem_after == 16'd0);
      rem_nxt   = rem_after;
      cl_nxt    = cl_after;
      if (last_flag) begin
        phase_nxt = PH_IDLE;
      end else if (cl_after != 4'd0) begin
        phase_nxt = PH_DELTA;
        field_nxt = '0;
        bl_nxt    = {1'b0, dw_nxt};
        ft_nxt    = {1'b0, dw_nxt};
      end else begin
        phase_nxt = PH_WIDTH;
        field_nxt = '0;
        bl_nxt    = WIDTH_BITS;
        ft_nxt    = WIDTH_BITS;
      end
    end

    cmd_push   = emit_go || st_go;
    cmd.value  = emit_go ? run_nxt[15:0] : 16'd0;
    cmd.status = emit_go ? dcd_pkg::ST_VALUE : st_code;
    cmd.reps   = emit_go ? emit_reps : dcd_pkg::REPS_W'(1);
    cmd.last   = emit_go ? last_flag : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      act_r   <= 1'b0;
      ew_r    <= '0;
      field_r <= '0;
      bl_r    <= '0;
      ft_r    <= '0;
      run_r   <= '0;
      rem_r   <= '0;
      cl_r    <= '0;
      dw_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      act_r   <= act_nxt;
      ew_r    <= ew_nxt;
      field_r <= field_nxt;
      bl_r    <= bl_nxt;
      ft_r    <= ft_nxt;
      run_r   <= run_nxt;
      rem_r   <= rem_nxt;
      cl_r    <= cl_nxt;
      dw_r    <= dw_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/dcd_back.sv */
// ----------------------------------------------------------------------------
// DCD result back
// Expands queued commands into single results and holds them in the output
// register until popped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dc_delta_bundle_decoder_macros.svh"

module dcd_back (
  input  wire                      clk,
  input  wire                      rst_n,
  input  dcd_pkg::cmd_t            q_head,
  input  dcd_pkg::q_stat_t         q_stat,
  output logic                     q_pop,
  output logic                     out_empty,
  input  wire                      out_pop,
  output logic signed [15:0]       out_dc_value,
  output logic [2:0]               out_status,
  output logic                     out_last
);

  logic                        out_valid_r;
  logic [15:0]                 value_r;
  logic [2:0]                  status_r;
  logic                        last_r;
  logic [dcd_pkg::REPS_W-1:0]  sent_r, sent_nxt;
  logic                        slot_free, issue, final_rep;

  // output slot frees up when empty or being popped
  assign slot_free = !out_valid_r || out_pop;
  assign issue     = slot_free && !q_stat.empty;
  assign final_rep = ((sent_r + 1'b1) == q_head.reps);
  assign q_pop     = issue && final_rep;
  assign sent_nxt  = final_rep ? '0 : sent_r + 1'b1;

  assign out_empty    = !out_valid_r;
  assign out_dc_value = $signed(value_r);
  assign out_status   = status_r;
  assign out_last     = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= '0;
    end else begin
      if (issue) begin
        out_valid_r <= 1'b1;
        sent_r      <= sent_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (issue) begin
      value_r  <= q_head.value;
      status_r <= q_head.status;
      last_r   <= q_head.last && final_rep;
    end
  end

  `DCD_ASSERT(a_sent_below_reps, !q_stat.empty |-> (sent_r < q_head.reps), "repeat count overrun")
  `DCD_ASSERT(a_reps_in_range, !q_stat.empty |-> (q_head.reps != '0 && q_head.reps <= dcd_pkg::CHUNK_EFF_REPS), "bad repeat count")
  `DCD_NEVER(a_status_single, !q_stat.empty && q_head.status != dcd_pkg::ST_VALUE && (q_head.reps != dcd_pkg::REPS_W'(1) || !q_head.last), "status request not single and last")
  `DCD_NEVER(a_idle_sent, q_stat.empty && sent_r != '0, "partial burst with empty queue")

endmodule

`default_nettype wire

/* hdl/dc_delta_bundle_decoder.sv */
// ----------------------------------------------------------------------------
// DC delta bundle decoder
// Bit-serial decoder for a bundle of 16-bit DC values with chunked deltas.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | in_push / in_full  | in_func, in_bit_value, in_unread_pending
//   result   | out_empty / out_pop| out_dc_value, out_status, out_last
//   config   | cfg_we             | cfg_index, cfg_wdata
//
// One request is taken every cycle while the four-entry command queue has room.
// A result passes through the command queue and the output register; the
// register gives one result a cycle while out_pop frees it, so a zero-width
// chunk (up to eight repeats from one command) fills the queue and backs up
// in_full while it drains. Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dc_delta_bundle_decoder (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_push,
  output logic                             in_full,
  input  wire  [1:0]                       in_func,
  input  wire                              in_bit_value,
  input  wire                              in_unread_pending,
  output logic                             out_empty,
  input  wire                              out_pop,
  output logic signed [15:0]               out_dc_value,
  output logic [2:0]                       out_status,
  output logic                             out_last,
  input  wire                              cfg_we,
  input  wire  [dcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [23:0]                      cfg_wdata
);

  dcd_pkg::cfg_t     cfg_r;
  dcd_pkg::cmd_t     cmd, q_head;
  dcd_pkg::q_stat_t  q_stat;
  logic              cmd_push, q_pop, in_acc;

  assign in_full = q_stat.full;
  assign in_acc  = in_push && !q_stat.full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_len        <= 5'd10;
      cfg_r.start_bits       <= 5'd11;
      cfg_r.signed_mode      <= 1'b0;
      cfg_r.capacity_entries <= 24'd65536;
      cfg_r.bit_order        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dcd_pkg::REG_COUNT_LEN:   cfg_r.count_len        <= cfg_wdata[4:0];
        dcd_pkg::REG_START_BITS:  cfg_r.start_bits       <= cfg_wdata[4:0];
        dcd_pkg::REG_SIGNED_MODE: cfg_r.signed_mode      <= cfg_wdata[0];
        dcd_pkg::REG_CAPACITY:    cfg_r.capacity_entries <= cfg_wdata;
        dcd_pkg::REG_BIT_ORDER:   cfg_r.bit_order        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dcd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_acc            (in_acc),
    .in_func           (in_func),
    .in_bit_value      (in_bit_value),
    .in_unread_pending (in_unread_pending),
    .cmd_push          (cmd_push),
    .cmd               (cmd)
  );

  dcd_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  dcd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (q_head),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_dc_value (out_dc_value),
    .out_status   (out_status),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// DC delta bundle decoder testbench
// Feeds bit-serial requests (start, stream bits, end, new frame) into the
// decoder and checks every result against a cycle-free model of the decoding
// rules. Directed rows cover reset, stray and skipped requests, empty counts,
// calls restarted midway, repeats and buffer overflow. Random bundles then run
// under many register settings, with idle bursts on both sides and a long
// receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  import dcd_pkg::*;

  // decoding phase of the model
  typedef enum logic [2:0] {
    DS_IDLE, DS_COUNT, DS_SEED, DS_SEED_SIGN, DS_WIDTH, DS_DELTA, DS_DELTA_SIGN
  } dec_state_e;

  typedef struct packed {
    logic [15:0] value;
    logic [2:0]  status;
    logic        is_last;
  } dc_result_t;

  // one directed row; typed rows carry the result that must come out
  typedef struct packed {
    logic [1:0]  fn;
    logic        b;
    logic        pend;
    logic        typed;
    logic [15:0] value;
    logic [2:0]  status;
    logic        is_last;
  } table_row_t;

  localparam table_row_t ZERO_BIT = '{FN_DATA, 1'b0, 1'b0, 1'b0, 16'd0, ST_VALUE, 1'b0};
  localparam table_row_t ONE_BIT  = '{FN_DATA, 1'b1, 1'b0, 1'b0, 16'd0, ST_VALUE, 1'b0};
  localparam table_row_t START    = '{FN_START, 1'b0, 1'b0, 1'b0, 16'd0, ST_VALUE, 1'b0};
  localparam table_row_t FRAME    = '{FN_FRAME, 1'b0, 1'b0, 1'b0, 16'd0, ST_VALUE, 1'b0};
  localparam int RESET_ROWS = 16;
  localparam int ALL_ROWS   = 29;

  // rows up to RESET_ROWS run with reset settings, the rest with
  // count_len 2, start_bits 1, signed, capacity 3, LSB first
  localparam table_row_t DIR_ROWS [ALL_ROWS] = '{
    // start before any frame is skipped
    '{FN_START, 1'b0, 1'b0, 1'b1, 16'd0, ST_SKIPPED, 1'b1},
    // stray bit and end while idle do nothing
    ONE_BIT,
    '{FN_END, 1'b0, 1'b0, 1'b0, 16'd0, ST_VALUE, 1'b0},
    FRAME,
    // unread entries pending
    '{FN_START, 1'b0, 1'b1, 1'b1, 16'd0, ST_SKIPPED, 1'b1},
    // ten-bit zero count
    START,
    ZERO_BIT, ZERO_BIT, ZERO_BIT, ZERO_BIT, ZERO_BIT, ZERO_BIT, ZERO_BIT, ZERO_BIT,
    ZERO_BIT,
    '{FN_DATA, 1'b0, 1'b0, 1'b1, 16'd0, ST_EMPTY, 1'b1},
    // small settings: restart mid-count, zero-bit seed, zero-width repeats
    FRAME,
    START,
    ONE_BIT,
    START,
    ONE_BIT, ONE_BIT,
    ZERO_BIT, ZERO_BIT, ZERO_BIT, ZERO_BIT,
    // three written, three more do not fit
    START,
    ONE_BIT,
    '{FN_DATA, 1'b1, 1'b0, 1'b1, 16'd0, ST_OVERFLOW, 1'b1}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_push;
  logic                   in_full;
  logic [1:0]             in_func;
  logic                   in_bit_value;
  logic                   in_unread_pending;
  logic                   out_empty;
  logic                   out_pop;
  logic signed [15:0]     out_dc_value;
  logic [2:0]             out_status;
  logic                   out_last;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [23:0]            cfg_wdata;

  // model registers
  logic [4:0]  cl_reg;
  logic [4:0]  sb_reg;
  logic        sm_reg;
  logic [23:0] cap_reg;
  logic        msb_reg;

  // model state
  bit          bundle_on;
  logic [23:0] frame_entries;
  dec_state_e  dstate;
  logic [15:0] field_bits;
  int          field_left;
  int          field_len;
  int          run_val;
  logic [15:0] entries_left;
  int          chunk_rem;
  logic [3:0]  delta_w;

  dc_result_t  step_results[$];
  dc_result_t  pending_results[$];
  int          error_count = 0;
  int          decoded_requests = 0;
  bit          idle_on = 1'b0;
  bit          long_hold = 1'b0;

  dc_delta_bundle_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_func           (in_func),
    .in_bit_value      (in_bit_value),
    .in_unread_pending (in_unread_pending),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_dc_value      (out_dc_value),
    .out_status        (out_status),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model
  function void add_result(logic [15:0] v, logic [2:0] st, logic lst);
    step_results.push_back('{v, st, lst});
  endfunction

  function void begin_field(dec_state_e s, int nbits);
    dstate     = s;
    field_bits = '0;
    field_left = nbits;
    field_len  = nbits;
  endfunction

  // one decoded entry leaves; pick the next field
  function void emit_entry();
    logic lst;
    frame_entries = frame_entries + 24'd1;
    entries_left  = entries_left - 16'd1;
    if (chunk_rem > 0) chunk_rem--;
    lst = (entries_left == 16'd0);
    add_result(run_val[15:0], ST_VALUE, lst);
    if (lst) dstate = DS_IDLE;
    else if (chunk_rem > 0) begin_field(DS_DELTA, delta_w);
    else begin_field(DS_WIDTH, 4);
  endfunction

  function void close_count();
    int sz;
    int seed_len;
    if (field_bits == 16'd0) begin
      bundle_on = 1'b0;
      dstate    = DS_IDLE;
      add_result('0, ST_EMPTY, 1'b1);
      return;
    end
    if (32'(frame_entries) + 32'(field_bits) > 32'(cap_reg)) begin
      dstate = DS_IDLE;
      add_result('0, ST_OVERFLOW, 1'b1);
      return;
    end
    entries_left = field_bits;
    chunk_rem    = 0;
    sz           = (sb_reg > 5'd16) ? 16 : int'(sb_reg);
    seed_len     = (sz > int'(sm_reg)) ? sz - int'(sm_reg) : 0;
    if (seed_len == 0) begin
      run_val = 0;
      emit_entry();
    end else begin
      begin_field(DS_SEED, seed_len);
    end
  endfunction

  function void add_delta(int d);
    int v;
    v = run_val + d;
    if (v < -32768 || v > 32767) begin
      dstate = DS_IDLE;
      add_result('0, ST_RANGE, 1'b1);
    end else begin
      run_val = v;
      emit_entry();
    end
  endfunction

  function void close_field();
    case (dstate)
      DS_COUNT: close_count();
      DS_SEED: begin
        if (sm_reg && field_bits != 16'd0) begin
          dstate     = DS_SEED_SIGN;
          field_left = 1;
        end else begin
          // unsigned 16-bit seed may exceed 32767 and wraps on output
          run_val = int'(field_bits);
          emit_entry();
        end
      end
      DS_WIDTH: begin
        chunk_rem = (int'(entries_left) < CHUNK_EFF) ? int'(entries_left) : CHUNK_EFF;
        if (field_bits == 16'd0) begin
          while (chunk_rem > 0 && dstate != DS_IDLE) emit_entry();
        end else begin
          delta_w = field_bits[3:0];
          begin_field(DS_DELTA, delta_w);
        end
      end
      DS_DELTA: begin
        if (field_bits != 16'd0) begin
          dstate     = DS_DELTA_SIGN;
          field_left = 1;
        end else begin
          add_delta(0);
        end
      end
      default: ;
    endcase
  endfunction

  // decode one accepted request into step_results; 0 when it is ignored
  function bit decode_request(logic [1:0] fn, logic b, logic pend);
    int m;
    int cl;
    step_results.delete();
    case (fn)
      FN_START: begin
        dstate = DS_IDLE;
        if (!bundle_on || pend) begin
          add_result('0, ST_SKIPPED, 1'b1);
          return 1'b1;
        end
        cl = (cl_reg > 5'd16) ? 16 : int'(cl_reg);
        begin_field(DS_COUNT, cl);
        if (cl == 0) close_count();
        return 1'b1;
      end
      FN_END: begin
        if (dstate == DS_IDLE) return 1'b0;
        dstate = DS_IDLE;
        add_result('0, ST_TRUNC, 1'b1);
        return 1'b1;
      end
      FN_FRAME: begin
        bundle_on     = 1'b1;
        frame_entries = '0;
        dstate        = DS_IDLE;
        return 1'b1;
      end
      default: ;
    endcase
    if (dstate == DS_IDLE) return 1'b0;
    m = int'(field_bits);
    if (dstate == DS_SEED_SIGN) begin
      run_val = b ? -m : m;
      emit_entry();
      return 1'b1;
    end
    if (dstate == DS_DELTA_SIGN) begin
      add_delta(b ? -m : m);
      return 1'b1;
    end
    if (field_left == 0) begin
      close_field();
      return 1'b1;
    end
    if (msb_reg) field_bits = {field_bits[14:0], b};
    else field_bits = field_bits | (16'(b) << ((field_len - field_left) & 15));
    field_left--;
    if (field_left == 0) close_field();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- driving
  // offer one request, wait for it to be taken, then decode it
  task automatic push_req(logic [1:0] fn, logic b, logic pend);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_func           <= fn;
    in_bit_value      <= b;
    in_unread_pending <= pend;
    do @(posedge clk); while (in_full);
    if (decode_request(fn, b, pend)) decoded_requests++;
  endtask

  task automatic send_req(logic [1:0] fn, logic b, logic pend);
    push_req(fn, b, pend);
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endtask

  task automatic walk_rows(int first, int stop);
    for (int r = first; r < stop; r++) begin
      push_req(DIR_ROWS[r].fn, DIR_ROWS[r].b, DIR_ROWS[r].pend);
      if (DIR_ROWS[r].typed)
        pending_results.push_back('{DIR_ROWS[r].value, DIR_ROWS[r].status,
                                    DIR_ROWS[r].is_last});
      else
        foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
  endtask

  // stream bits of a field in the current bit order
  task automatic send_field(logic [15:0] v, int nbits);
    for (int i = 0; i < nbits; i++)
      send_req(FN_DATA, msb_reg ? v[nbits - 1 - i] : v[i], 1'($urandom_range(0, 1)));
  endtask

  // registers change only once the decoder has gone quiet
  task automatic set_config(logic [4:0] cl, logic [4:0] sb, logic sm, logic [23:0] cap,
                            logic msb);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COUNT_LEN;   cfg_wdata <= 24'(cl);  @(posedge clk);
    cfg_index <= REG_START_BITS;  cfg_wdata <= 24'(sb);  @(posedge clk);
    cfg_index <= REG_SIGNED_MODE; cfg_wdata <= 24'(sm);  @(posedge clk);
    cfg_index <= REG_CAPACITY;    cfg_wdata <= cap;      @(posedge clk);
    cfg_index <= REG_BIT_ORDER;   cfg_wdata <= 24'(msb); @(posedge clk);
    cfg_we <= 1'b0;
    cl_reg  = cl;
    sb_reg  = sb;
    sm_reg  = sm;
    cap_reg = cap;
    msb_reg = msb;
  endtask

  // one well-formed call with random content, now and then cut short
  task automatic send_bundle(bit only_repeats);
    int cl;
    int max_cnt;
    int cnt;
    int sz;
    int seed_len;
    int left;
    int chunk;
    int w;
    logic [15:0] mag;
    send_req(FN_START, 1'b0, ($urandom_range(0, 15) == 0));
    cl = (cl_reg > 5'd16) ? 16 : int'(cl_reg);
    if (cl == 0) return;
    max_cnt = (cl >= 4) ? 12 : (1 << cl) - 1;
    if (only_repeats) cnt = max_cnt;
    else if ($urandom_range(0, 19) == 0) cnt = 0;
    else cnt = $urandom_range(1, max_cnt);
    send_field(16'(cnt), cl);
    if (cnt == 0) return;
    sz       = (sb_reg > 5'd16) ? 16 : int'(sb_reg);
    seed_len = (sz > int'(sm_reg)) ? sz - int'(sm_reg) : 0;
    if (seed_len > 0) begin
      mag = 16'($urandom & ((32'd1 << seed_len) - 32'd1));
      send_field(mag, seed_len);
      if (sm_reg && mag != 16'd0) send_req(FN_DATA, 1'($urandom_range(0, 1)), 1'b0);
    end
    left = cnt - 1;
    while (left > 0) begin
      if (!only_repeats && $urandom_range(0, 29) == 0) begin
        send_req($urandom_range(0, 1) ? FN_END : FN_START, 1'b0, 1'b0);
        return;
      end
      chunk = (left < CHUNK_EFF) ? left : CHUNK_EFF;
      if (only_repeats || $urandom_range(0, 3) == 0) w = 0;
      else if ($urandom_range(0, 7) == 0) w = $urandom_range(6, 15);
      else w = $urandom_range(1, 5);
      send_field(16'(w), 4);
      if (w != 0) begin
        for (int k = 0; k < chunk; k++) begin
          mag = 16'($urandom & ((32'd1 << w) - 32'd1));
          send_field(mag, w);
          if (mag != 16'd0) send_req(FN_DATA, 1'($urandom_range(0, 1)), 1'b0);
        end
      end
      left -= chunk;
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin
    int nb;
    logic [4:0]  cl_pick;
    logic [4:0]  sb_pick;
    logic [23:0] cap_pick;
    rst_n             = 1'b0;
    in_push           = 1'b0;
    in_func           = FN_DATA;
    in_bit_value      = 1'b0;
    in_unread_pending = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_COUNT_LEN;
    cfg_wdata         = '0;
    // model at reset
    cl_reg        = 5'd10;
    sb_reg        = 5'd11;
    sm_reg        = 1'b0;
    cap_reg       = 24'd65536;
    msb_reg       = 1'b0;
    bundle_on     = 1'b0;
    frame_entries = '0;
    begin_field(DS_IDLE, 0);
    run_val       = 0;
    entries_left  = '0;
    chunk_rem     = 0;
    delta_w       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    walk_rows(0, RESET_ROWS);
    set_config(5'd2, 5'd1, 1'b1, 24'd3, 1'b0);
    walk_rows(RESET_ROWS, ALL_ROWS);

    // receiver holds off while repeats pile up; wide unsigned seeds
    set_config(5'd5, 5'd16, 1'b0, 24'hFFFFFF, 1'b1);
    send_req(FN_FRAME, 1'b0, 1'b0);
    long_hold = 1'b1;
    repeat (3) send_bundle(1'b1);

    // random phases, each under its own register settings
    decoded_requests = 0;
    while (decoded_requests < 410) begin
      case ($urandom_range(0, 9))
        0:       cl_pick = 5'd0;
        1:       cl_pick = 5'd1;
        2:       cl_pick = 5'd16;
        3:       cl_pick = 5'($urandom_range(17, 31));
        default: cl_pick = 5'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       sb_pick = 5'd0;
        1:       sb_pick = 5'd1;
        2:       sb_pick = 5'd16;
        3:       sb_pick = 5'd31;
        default: sb_pick = 5'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       cap_pick = 24'd0;
        1:       cap_pick = 24'hFFFFFF;
        2:       cap_pick = 24'($urandom);
        default: cap_pick = 24'($urandom_range(4, 60));
      endcase
      idle_on = 1'b0;
      set_config(cl_pick, sb_pick, 1'($urandom_range(0, 1)), cap_pick,
                 1'($urandom_range(0, 1)));
      send_req(FN_FRAME, 1'b0, 1'b0);
      nb = $urandom_range(4, 10);
      for (int n = 0; n < nb && decoded_requests < 410; n++) begin
        // last stretch of the run goes without idling
        idle_on = (decoded_requests < 350) && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0: begin
            // noise
            repeat ($urandom_range(1, 6))
              send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
          end
          1: send_req(FN_FRAME, 1'b0, 1'b0);
          default: send_bundle(1'b0);
        endcase
      end
    end

    // drain and finish
    idle_on = 1'b0;
    in_push <= 1'b0;
    for (int w = 0; w < 5000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      error_count += pending_results.size();
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold when asked
  initial begin
    out_pop = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_pop <= 1'b0;
        repeat (80) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    dc_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: value %0d status %0d last %0d",
                   out_dc_value, out_status, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_dc_value !== want.value || out_status !== want.status ||
            out_last !== want.is_last) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: got value %0d status %0d last %0d, want %0d %0d %0d",
                     out_dc_value, out_status, out_last, $signed(want.value),
                     want.status, want.is_last);
        end
      end
    end
  end

  // hang guard
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
